[rtl/wssd_pkg.sv]
// Package for the WAV stream sample decoder: shared types and constants.
// No dependencies.
package wssd_pkg;
  localparam logic [31:0] TAG_FMT  = 32'h20746D66;
  localparam logic [31:0] TAG_DATA = 32'h61746164;
  localparam logic [15:0] FMT_PCM  = 16'h0001;
  localparam logic [15:0] FMT_FLT  = 16'h0003;
  localparam logic [15:0] FMT_EXT  = 16'hFFFE;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOTWAV  = 3'd1;
  localparam logic [2:0] ST_MISSING = 3'd2;
  localparam logic [2:0] ST_BADENC  = 3'd3;
  localparam logic [2:0] ST_BADFMT  = 3'd4;
  localparam logic [2:0] ST_NOFRAME = 3'd5;
  localparam logic [2:0] ST_EARLY   = 3'd6;

  // sample conversion kinds
  typedef enum logic [2:0] {
    CV_U8, CV_S16, CV_S24, CV_S32, CV_F32, CV_F64
  } conv_t;

  // job handed from front to back
  typedef struct packed {
    logic        is_status;
    conv_t       conv;
    logic [63:0] raw;
    logic [15:0] chan;
    logic [2:0]  status;
    logic [31:0] rate;
    logic [15:0] count;
  } job_t;
endpackage

[rtl/wssd_front.sv]
// Front end: parses the byte stream, gathers sample bytes, emits jobs.
// Depends on wssd_pkg.
module wssd_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       file_byte,
  input  logic             last_byte,
  output logic             job_valid,
  output wssd_pkg::job_t   job,
  input  logic             job_ready,
  output logic             div_start,
  output logic [31:0]      div_num,
  output logic [31:0]      div_den,
  input  logic             div_done,
  input  logic [31:0]      div_quo
);
  typedef enum logic [3:0] {
    PH_RIFF, PH_CHDR, PH_FMT, PH_DATA, PH_SKIP, PH_PAD, PH_STOP, PH_DEAD,
    PH_DIV1, PH_DIV2, PH_MUL
  } phase_t;

  phase_t      phase;
  logic [31:0] pos, tag, clen, rate, left;
  logic [15:0] fcode, chans, bps, ccnt;
  logic        fmt_found, data_found, data_begun;
  logic [2:0]  err;
  logic [63:0] gather;
  logic [3:0]  sbyte;
  logic [7:0]  lo24;
  logic [31:0] quo1;

  // two queued jobs max per byte: sample plus status
  wssd_pkg::job_t q [2];
  logic [1:0]     qn;

  wssd_pkg::job_t samp_j, stat_j;
  logic           emit_samp, work;
  logic [31:0]    pos1;
  logic [3:0]     nbytes;
  logic [2:0]     st;
  logic [31:0]    gsh;

  assign nbytes   = bps[6:3];
  assign in_ready = (qn == 2'd0) &&
                    !(phase == PH_DIV1 || phase == PH_DIV2 || phase == PH_MUL);
  assign work     = in_valid && in_ready;
  assign pos1     = pos + 32'd1;
  assign job_valid = (qn != 2'd0);
  assign job       = q[0];
  assign gsh       = 32'(file_byte) << {sbyte[1:0], 3'b000};

  always_comb begin
    wssd_pkg::conv_t c;
    if (fcode == wssd_pkg::FMT_FLT) c = (bps == 16'd32) ? wssd_pkg::CV_F32 : wssd_pkg::CV_F64;
    else begin
      case (bps)
        16'd8:   c = wssd_pkg::CV_U8;
        16'd16:  c = wssd_pkg::CV_S16;
        16'd24:  c = wssd_pkg::CV_S24;
        default: c = wssd_pkg::CV_S32;
      endcase
    end
    samp_j = '0;
    samp_j.conv = c;
    samp_j.raw  = gather | (64'(file_byte) << {sbyte[2:0], 3'b000});
    samp_j.chan = ccnt;
  end

  assign emit_samp = work && phase == PH_DATA && left != 32'd0 &&
                     ({28'd0, sbyte} + 32'd1 >= {28'd0, nbytes});

  always_comb begin
    logic rphase;
    rphase = (phase == PH_RIFF) || (phase == PH_RIFF) ;
    if (phase == PH_RIFF || err == wssd_pkg::ST_NOTWAV) st = wssd_pkg::ST_NOTWAV;
    else if (err == wssd_pkg::ST_EARLY) st = wssd_pkg::ST_EARLY;
    else if (!fmt_found || !data_found) st = wssd_pkg::ST_MISSING;
    else st = err;
    stat_j = '0;
    stat_j.is_status = rphase;
    stat_j.is_status = 1'b1;
    stat_j.status = st;
    stat_j.rate   = (st == wssd_pkg::ST_OK) ? rate : 32'd0;
    stat_j.count  = (st == wssd_pkg::ST_OK) ? chans : 16'd0;
  end

  // RIFF header byte check: positions 0-3 must read RIFF and 8-11 WAVE; other positions pass
  function automatic logic riff_ok(input logic [31:0] p, input logic [7:0] b);
    logic [7:0] e;
    case (p[3:0])
      4'd0: e = 8'h52; 4'd1: e = 8'h49; 4'd2: e = 8'h46; 4'd3: e = 8'h46;
      4'd8: e = 8'h57; 4'd9: e = 8'h41; 4'd10: e = 8'h56; 4'd11: e = 8'h45;
      default: e = b;
    endcase
    return (p >= 32'd12) || (b == e);
  endfunction

  always_ff @(posedge clk) begin
    logic        ff, df, lb;
    logic        sampq;
    phase_t      ph;
    logic [31:0] p;
    logic [2:0]  er;
    if (rst) begin
      phase <= PH_RIFF; pos <= '0; tag <= '0; clen <= '0; rate <= '0; left <= '0;
      fcode <= '0; chans <= '0; bps <= '0; ccnt <= '0; fmt_found <= 1'b0;
      data_found <= 1'b0; data_begun <= 1'b0; err <= '0; gather <= '0; sbyte <= '0;
      qn <= '0; div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (job_valid && job_ready) begin
        q[0] <= q[1];
        qn   <= qn - 2'd1;
      end
      case (phase)
        PH_DIV1: if (div_done) begin
          quo1 <= div_quo; div_num <= div_quo; div_den <= {16'd0, chans};
          div_start <= 1'b1; phase <= PH_DIV2;
        end
        PH_DIV2: if (div_done) begin
          quo1 <= div_quo; phase <= PH_MUL;
        end
        PH_MUL: begin
          if (quo1 == 32'd0) err <= wssd_pkg::ST_NOFRAME;
          else left <= quo1 * {16'd0, chans};
          phase <= (clen == 32'd0) ? PH_CHDR : PH_DATA;
        end
        default: ;
      endcase
      if (work) begin
        ph = phase; p = pos; ff = fmt_found; df = data_found; lb = last_byte;
        er = err;
        sampq = 1'b0;
        case (phase)
          PH_RIFF: begin
            if (!riff_ok(pos, file_byte)) begin
              ph = PH_DEAD; err <= wssd_pkg::ST_NOTWAV;
            end else if (pos1 >= 32'd12) begin
              p = 32'd0; ph = PH_CHDR;
            end else p = pos1;
          end
          PH_CHDR: begin
            logic [31:0] t, l;
            t = tag; l = clen;
            if (pos < 32'd4) t[pos[1:0]*8 +: 8] = file_byte;
            else l[pos[1:0]*8 +: 8] = file_byte;
            tag <= t; clen <= l;
            p = pos1;
            if (pos1 >= 32'd8) begin
              p = 32'd0; ph = (l == 32'd0) ? PH_CHDR : PH_SKIP;
              if (!data_begun) begin
                if (t == wssd_pkg::TAG_FMT) begin
                  if (l < 32'd16) ph = PH_STOP;
                  else if (l != 32'd0) ph = PH_FMT;
                end else if (t == wssd_pkg::TAG_DATA) begin
                  data_begun <= 1'b1;
                  if (!fmt_found) begin
                    err <= wssd_pkg::ST_EARLY; er = wssd_pkg::ST_EARLY;
                  end else begin
                    logic ok;
                    left <= '0; ccnt <= '0; sbyte <= '0; gather <= '0;
                    ph = (l == 32'd0) ? PH_CHDR : PH_DATA;
                    ok = (fcode == wssd_pkg::FMT_FLT) ? (bps == 16'd32 || bps == 16'd64)
                       : (bps == 16'd8 || bps == 16'd16 || bps == 16'd24 || bps == 16'd32);
                    if (fcode != wssd_pkg::FMT_PCM && fcode != wssd_pkg::FMT_FLT)
                      err <= wssd_pkg::ST_BADENC;
                    else if (!ok || chans == 16'd0 || rate == 32'd0)
                      err <= wssd_pkg::ST_BADFMT;
                    else begin
                      err <= wssd_pkg::ST_OK;
                      // frame count needs two divides; stall input meanwhile
                      div_num <= l; div_den <= {28'd0, nbytes};
                      div_start <= 1'b1; ph = PH_DIV1;
                    end
                  end
                end
              end
            end
          end
          PH_FMT: begin
            if (pos < 32'd2) fcode[pos[0]*8 +: 8] <= file_byte;
            else if (pos < 32'd4) chans[pos[0]*8 +: 8] <= file_byte;
            else if (pos < 32'd8) rate[pos[1:0]*8 +: 8] <= file_byte;
            else if (pos == 32'd14) bps[7:0] <= file_byte;
            else if (pos == 32'd15) bps[15:8] <= file_byte;
            else if (pos == 32'd24) lo24 <= file_byte;
            else if (pos == 32'd25 && fcode == wssd_pkg::FMT_EXT)
              fcode <= {file_byte, lo24};
            p = pos1;
            if (pos1 == clen) begin
              ff = 1'b1; p = 32'd0; ph = clen[0] ? PH_PAD : PH_CHDR;
            end
          end
          PH_DATA: begin
            if (left != 32'd0) begin
              if (emit_samp) begin
                sampq = 1'b1; gather <= '0; sbyte <= '0; left <= left - 32'd1;
                ccnt <= (ccnt + 16'd1 >= chans) ? 16'd0 : ccnt + 16'd1;
              end else begin
                gather <= samp_j.raw; sbyte <= sbyte + 4'd1;
              end
            end
            p = pos1;
            if (pos1 == clen) begin
              df = 1'b1; p = 32'd0; ph = clen[0] ? PH_PAD : PH_CHDR;
            end
          end
          PH_SKIP: begin
            p = pos1;
            if (pos1 == clen) begin p = 32'd0; ph = clen[0] ? PH_PAD : PH_CHDR; end
          end
          PH_PAD: begin ph = PH_CHDR; p = 32'd0; end
          default: ;
        endcase
        phase <= ph; pos <= p; fmt_found <= ff; data_found <= df;
        if (sampq) begin
          q[0] <= samp_j; qn <= 2'd1;
        end
        if (lb) begin
          wssd_pkg::job_t s;
          s = stat_j;
          if (ph == PH_RIFF || er == wssd_pkg::ST_NOTWAV ||
              (phase == PH_RIFF && ph == PH_DEAD)) s.status = wssd_pkg::ST_NOTWAV;
          else if (er == wssd_pkg::ST_EARLY) s.status = wssd_pkg::ST_EARLY;
          else if (!ff || !df) s.status = wssd_pkg::ST_MISSING;
          else s.status = er;
          s.rate  = (s.status == wssd_pkg::ST_OK) ? rate : 32'd0;
          s.count = (s.status == wssd_pkg::ST_OK) ? chans : 16'd0;
          if (sampq) begin q[1] <= s; qn <= 2'd2; end
          else begin q[0] <= s; qn <= 2'd1; end
          phase <= PH_RIFF; pos <= '0; tag <= '0; clen <= '0; rate <= '0; left <= '0;
          fcode <= '0; chans <= '0; bps <= '0; ccnt <= '0; fmt_found <= 1'b0;
          data_found <= 1'b0; data_begun <= 1'b0; err <= '0; gather <= '0; sbyte <= '0;
        end
      end
    end
  end
endmodule

[rtl/wssd_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
// No dependencies.
module wssd_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quo
);
  logic [31:0] rem, d;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] trial;

  assign trial = {rem, quo[31]} - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; done <= 1'b0; cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1; rem <= '0; quo <= num; d <= den; cnt <= 6'd32;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial[31:0]; quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quo[31]}; quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin busy <= 1'b0; done <= 1'b1; end
      end
    end
  end
endmodule

[rtl/wssd_back.sv]
// Back end: turns queued jobs into IEEE single sample results and status results, two pipeline stages.
// Depends on wssd_pkg.
module wssd_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  input  wssd_pkg::job_t   job,
  output logic             job_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             result_kind,
  output logic [31:0]      sample_value,
  output logic [15:0]      channel_index,
  output logic [2:0]       status,
  output logic [31:0]      sample_rate,
  output logic [15:0]      channel_count,
  output logic             last
);
  // stage 1: leading one position, stage 2: round and pack
  logic            s1v;
  wssd_pkg::job_t  s1;
  logic [31:0]     mag;
  logic            sgn;
  logic [4:0]      lead;
  logic            zero;
  logic            adv1, adv2;
  logic [31:0]     val;

  assign adv2 = !out_valid || out_ready;
  assign adv1 = !s1v || adv2;
  assign job_ready = adv1;

  always_comb begin
    logic [31:0] r;
    case (job.conv)
      wssd_pkg::CV_U8:  r = {job.raw[7:0] ^ 8'h80, 24'd0};
      wssd_pkg::CV_S16: r = {job.raw[15:0], 16'd0};
      wssd_pkg::CV_S24: r = {job.raw[23:0], 8'd0};
      default:          r = job.raw[31:0];
    endcase
    sgn = r[31];
    mag = r[31] ? (32'd0 - r) : r;
  end

  always_comb begin
    lead = '0; zero = 1'b1;
    for (int i = 0; i < 32; i++) if (mag[i]) begin lead = 5'(i); zero = 1'b0; end
  end

  logic [31:0] s1mag;
  logic        s1sgn, s1zero;
  logic [4:0]  s1lead;

  function automatic logic [31:0] dbl(input logic [63:0] dd);
    logic [10:0] e;
    logic [52:0] m;
    logic [31:0] s;
    logic [53:0] k;
    logic [28:0] rm;
    logic [10:0] sh;
    logic [63:0] mm, kk, rr, hf;
    logic [9:0]  ex;
    s = {dd[63], 31'd0};
    e = dd[62:52];
    m = {1'b1, dd[51:0]};
    if (e == 11'h7FF)
      return (dd[51:0] != 52'd0) ? (s | 32'h7FC00000 | {10'd0, dd[50:29]}) : (s | 32'h7F800000);
    if (e == 11'd0) return s;
    if (e > 11'd1150) return s | 32'h7F800000;
    if (e >= 11'd897) begin
      rm = m[28:0];
      k = {25'd0, m[52:29]};
      if (rm > 29'h10000000 || (rm == 29'h10000000 && k[0])) k = k + 54'd1;
      ex = 10'(e - 11'd896);
      if (k[24]) begin k = k >> 1; ex = ex + 10'd1; end
      if (ex > 10'd254) return s | 32'h7F800000;
      return s | {1'b0, ex[7:0], k[22:0]};
    end
    sh = 11'd926 - e;
    if (sh > 11'd60) return s;
    mm = {11'd0, m};
    kk = mm >> sh;
    hf = 64'd1 << (sh - 11'd1);
    rr = mm & ((64'd1 << sh) - 64'd1);
    if (rr > hf || (rr == hf && kk[0])) kk = kk + 64'd1;
    return s | kk[31:0];
  endfunction

  always_comb begin
    logic [31:0] nm, keep, half, rr;
    logic [4:0]  sh;
    logic [7:0]  ex;
    nm = s1mag << (5'd31 - s1lead);
    ex = 8'd96 + {3'd0, s1lead};
    sh = 5'd8;
    keep = nm >> sh;
    rr   = nm & 32'hFF;
    half = 32'h80;
    if (s1lead > 5'd23 && (rr > half || (rr == half && keep[0]))) keep = keep + 32'd1;
    if (keep[24]) begin keep = keep >> 1; ex = ex + 8'd1; end
    case (s1.conv)
      wssd_pkg::CV_F32: val = s1.raw[31:0];
      wssd_pkg::CV_F64: val = dbl(s1.raw);
      default: val = s1zero ? 32'd0 : {s1sgn, ex, keep[22:0]};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1v <= 1'b0; out_valid <= 1'b0;
    end else begin
      if (adv1) begin
        s1v <= job_valid;
        s1 <= job; s1mag <= mag; s1sgn <= sgn; s1lead <= lead; s1zero <= zero;
      end
      if (adv2) begin
        out_valid     <= s1v;
        result_kind   <= s1.is_status;
        sample_value  <= s1.is_status ? 32'd0 : val;
        channel_index <= s1.is_status ? 16'd0 : s1.chan;
        status        <= s1.is_status ? s1.status : 3'd0;
        sample_rate   <= s1.is_status ? s1.rate : 32'd0;
        channel_count <= s1.is_status ? s1.count : 16'd0;
        last          <= s1.is_status;
      end
    end
  end
endmodule

[rtl/wav_stream_sample_decoder_core.sv]
// Top level of the WAV stream sample decoder: front parser, divider, back converter.
// Depends on wssd_pkg, wssd_front, wssd_div, wssd_back.
//
//  channel | signals                              | direction
//  in      | in_valid in_ready file_byte last_byte | into block
//  out     | out_valid out_ready result_kind ...   | out of block
//
// One byte per cycle while the job queue is empty and no frame count is being
// computed. A byte that queues a result holds off the next byte until the back
// end takes the job. At a data chunk header the front stalls for two 32-step
// divides (frame count) and one multiply.
// Reset is synchronous; rst returns every phase to the RIFF header.
// The back end stalls on out_ready; the two-entry job queue stalls the front.
module wav_stream_sample_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  file_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [31:0] sample_value,
  output logic [15:0] channel_index,
  output logic [2:0]  status,
  output logic [31:0] sample_rate,
  output logic [15:0] channel_count,
  output logic        last
);
  wssd_pkg::job_t job;
  logic           job_valid, job_ready;
  logic           div_start, div_done;
  logic [31:0]    div_num, div_den, div_quo;

  // parse bytes and queue jobs
  wssd_front u_front (
    .clk, .rst, .in_valid, .in_ready, .file_byte, .last_byte,
    .job_valid, .job, .job_ready,
    .div_start, .div_num, .div_den, .div_done, .div_quo
  );

  // frame count divider
  wssd_div u_div (
    .clk, .rst, .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  // convert and present results
  wssd_back u_back (
    .clk, .rst, .job_valid, .job, .job_ready,
    .out_valid, .out_ready, .result_kind, .sample_value, .channel_index,
    .status, .sample_rate, .channel_count, .last
  );
endmodule

[tb/sv/wav_stream_sample_decoder_core_tb.sv]
// Self-checking testbench for wav_stream_sample_decoder_core: WAV files in bytes,
// samples and end-of-file status out. Depends on wssd_pkg and the core RTL.
`timescale 1ns / 1ps

module wav_stream_sample_decoder_core_tb;
  import wssd_pkg::*;

  typedef enum logic [2:0] {
    PH_RIFF, PH_CHDR, PH_FMT, PH_DATA, PH_SKIP, PH_PAD, PH_STOP, PH_DEAD
  } phase_t;

  typedef struct {
    logic [7:0] fbyte;
    logic       lastb;
    logic       hold;   // wait until every expected result is out
  } byte_item_t;

  typedef struct {
    logic        kind;
    logic [31:0] val;
    logic [15:0] chan;
    logic [2:0]  st;
    logic [31:0] rate;
    logic [15:0] cnt;
    logic        lst;
  } result_t;

  localparam int WATCHDOG_LIMIT = 5000;

  logic clk, rst;
  logic in_valid, in_ready, last_byte;
  logic [7:0] file_byte;
  logic out_valid, out_ready, result_kind, last;
  logic [31:0] sample_value, sample_rate;
  logic [15:0] channel_index, channel_count;
  logic [2:0] status;

  wav_stream_sample_decoder_core dut (.*);

  byte_item_t pending_bytes[$];
  result_t    expected_results[$];
  logic [7:0] wav_buf[$];
  logic [7:0] data_fill[$];   // fixed sample bytes for directed files
  int mismatches = 0;
  bit failed = 0;
  int idle_cycles = 0;

  // predictor state
  phase_t      p_phase;
  logic [31:0] p_pos, p_tag, p_len, p_rate, p_left;
  logic [15:0] p_code, p_chans, p_bits, p_chan_ctr;
  logic        p_fmt_ok, p_data_ok, p_data_begun;
  logic [63:0] p_gather;
  logic [2:0]  p_err;
  logic [31:0] p_sbyte;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_parser();
    p_phase = PH_RIFF; p_pos = 0; p_tag = 0; p_len = 0; p_code = 0; p_chans = 0;
    p_rate = 0; p_bits = 0; p_fmt_ok = 0; p_data_ok = 0; p_data_begun = 0;
    p_left = 0; p_gather = 0; p_chan_ctr = 0; p_err = ST_OK; p_sbyte = 0;
  endfunction

  function automatic logic [63:0] round_even(logic [63:0] m, int s);
    logic [63:0] keep, rem, half;
    keep = m >> s;
    rem  = m & ((64'd1 << s) - 1);
    half = 64'd1 << (s - 1);
    if (rem > half || (rem == half && keep[0])) keep++;
    return keep;
  endfunction

  // signed 32-bit fraction of full scale to single bits
  function automatic logic [31:0] fixed_to_single(logic [31:0] raw);
    logic sgn;
    logic [63:0] mag, keep;
    logic [31:0] ex;
    int p;
    if (raw == 0) return 0;
    sgn = raw[31];
    mag = sgn ? {32'd0, -raw} : {32'd0, raw};
    p = 31;
    while (!mag[p]) p--;
    ex = p + 96;
    if (p > 23) begin
      keep = round_even(mag, p - 23);
      if (keep[24]) begin
        keep >>= 1;
        ex++;
      end
    end else begin
      keep = mag << (23 - p);
    end
    return {sgn, ex[7:0], keep[22:0]};
  endfunction

  function automatic logic [31:0] double_to_single(logic [63:0] d);
    logic [31:0] sgn;
    logic [10:0] e;
    logic [63:0] m, keep;
    int ex;
    sgn = {d[63], 31'd0};
    e = d[62:52];
    if (e == 11'h7FF)
      return (d[51:0] != 0) ? (sgn | 32'h7FC00000 | {9'd0, d[51:29]})
                            : (sgn | 32'h7F800000);
    if (e == 0) return sgn;
    m = {11'd1, d[51:0]};
    ex = int'(e) - 1023;
    if (ex > 127) return sgn | 32'h7F800000;
    if (ex >= -126) begin
      keep = round_even(m, 29);
      if (keep[24]) begin
        keep >>= 1;
        ex++;
      end
      if (ex > 127) return sgn | 32'h7F800000;
      return sgn | (32'(ex + 127) << 23) | {9'd0, keep[22:0]};
    end
    if (926 - int'(e) > 60) return sgn;
    keep = round_even(m, 926 - int'(e));
    return sgn | keep[31:0];
  endfunction

  function automatic logic [31:0] convert_gathered();
    logic [31:0] g;
    g = p_gather[31:0];
    if (p_code == FMT_FLT) return (p_bits == 32) ? g : double_to_single(p_gather);
    case (p_bits)
      16'd8:   return fixed_to_single({g[7] ^ 1'b1, g[6:0], 24'd0});
      16'd16:  return fixed_to_single({g[15:0], 16'd0});
      16'd24:  return fixed_to_single({g[23:0], 8'd0});
      default: return fixed_to_single(g);
    endcase
  endfunction

  function automatic void open_chunk();
    phase_t nxt;
    logic [31:0] bsz, frames;
    logic ok;
    nxt = PH_SKIP;
    if (!p_data_begun) begin
      if (p_tag == TAG_FMT) begin
        if (p_len < 16) begin
          p_phase = PH_STOP;
          return;
        end
        nxt = PH_FMT;
      end else if (p_tag == TAG_DATA) begin
        p_data_begun = 1;
        if (!p_fmt_ok) begin
          p_err = ST_EARLY;
        end else begin
          p_left = 0;
          p_err = ST_OK;
          if (p_code != FMT_PCM && p_code != FMT_FLT) begin
            p_err = ST_BADENC;
          end else begin
            ok = (p_code == FMT_FLT) ? (p_bits == 32 || p_bits == 64)
                 : (p_bits == 8 || p_bits == 16 || p_bits == 24 || p_bits == 32);
            if (!ok || p_chans == 0 || p_rate == 0) begin
              p_err = ST_BADFMT;
            end else begin
              bsz = p_bits / 8;
              frames = (p_len / bsz) / p_chans;
              if (frames == 0) p_err = ST_NOFRAME;
              else p_left = frames * p_chans;
            end
          end
          p_chan_ctr = 0; p_sbyte = 0; p_gather = 0;
          nxt = PH_DATA;
        end
      end
    end
    p_phase = (p_len == 0) ? PH_CHDR : nxt;
  endfunction

  function automatic void body_byte_done();
    p_pos++;
    if (p_pos == p_len) begin
      if (p_phase == PH_FMT) p_fmt_ok = 1;
      if (p_phase == PH_DATA) p_data_ok = 1;
      p_phase = p_len[0] ? PH_PAD : PH_CHDR;
      p_pos = 0;
    end
  endfunction

  // advance the parser by one accepted byte; queue the results it causes
  function automatic void predict_byte(logic [7:0] b, logic lastb);
    logic [31:0] pos;
    logic [7:0] tagb;
    logic [2:0] st;
    result_t r;
    pos = p_pos;
    case (p_phase)
      PH_RIFF: begin
        case (pos)
          0: tagb = "R";
          1: tagb = "I";
          2, 3: tagb = "F";
          8: tagb = "W";
          9: tagb = "A";
          10: tagb = "V";
          default: tagb = "E";
        endcase
        if (pos < 12 && (pos - 4) > 3 && b != tagb) begin
          p_phase = PH_DEAD;
          p_err = ST_NOTWAV;
        end else begin
          p_pos++;
          if (p_pos >= 12) begin
            p_pos = 0;
            p_phase = PH_CHDR;
          end
        end
      end
      PH_CHDR: begin
        if (pos < 4) p_tag[8*pos[1:0] +: 8] = b;
        else p_len[8*pos[1:0] +: 8] = b;
        p_pos++;
        if (p_pos >= 8) begin
          p_pos = 0;
          open_chunk();
        end
      end
      PH_FMT: begin
        if (pos < 2) p_code[8*pos[0] +: 8] = b;
        else if (pos < 4) p_chans[8*pos[0] +: 8] = b;
        else if (pos < 8) p_rate[8*pos[1:0] +: 8] = b;
        else if (pos == 14 || pos == 15) p_bits[8*pos[0] +: 8] = b;
        else if (pos == 24) p_gather = {56'd0, b};
        else if (pos == 25 && p_code == FMT_EXT) p_code = {b, p_gather[7:0]};
        body_byte_done();
      end
      PH_DATA: begin
        if (p_left > 0) begin
          p_gather |= {56'd0, b} << (8 * p_sbyte[2:0]);
          p_sbyte++;
          if (p_sbyte >= p_bits / 8) begin
            r = '{1'b0, convert_gathered(), p_chan_ctr, ST_OK, 32'd0, 16'd0, 1'b0};
            expected_results.push_back(r);
            p_gather = 0; p_sbyte = 0; p_left--;
            p_chan_ctr++;
            if (p_chan_ctr >= p_chans) p_chan_ctr = 0;
          end
        end
        body_byte_done();
      end
      PH_SKIP: body_byte_done();
      PH_PAD: begin
        p_phase = PH_CHDR;
        p_pos = 0;
      end
      default: ;
    endcase
    if (lastb) begin
      if (p_phase == PH_RIFF || p_err == ST_NOTWAV) st = ST_NOTWAV;
      else if (p_err == ST_EARLY) st = ST_EARLY;
      else if (!p_fmt_ok || !p_data_ok) st = ST_MISSING;
      else st = p_err;
      r = '{1'b1, 32'd0, 16'd0, st, (st == ST_OK) ? p_rate : 32'd0,
            (st == ST_OK) ? p_chans : 16'd0, 1'b1};
      expected_results.push_back(r);
      clear_parser();
    end
  endfunction

  // ---------------- file builder ----------------
  function automatic void put_le(logic [31:0] v, int n);
    for (int i = 0; i < n; i++) wav_buf.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_tag(string s);
    for (int i = 0; i < 4; i++) wav_buf.push_back(s[i]);
  endfunction

  // hand the built file to the driver; drop `cut` bytes from the end first
  function automatic void send_file(int cut, bit hold);
    byte_item_t it;
    int n;
    n = wav_buf.size() - cut;
    if (n < 1) n = 1;
    for (int i = 0; i < n; i++) begin
      it.fbyte = wav_buf[i];
      it.lastb = (i == n - 1);
      it.hold  = hold && (i == 0);
      pending_bytes.push_back(it);
    end
    wav_buf.delete();
  endfunction

  // code/sub: format code and extensible subformat; fmt_len below 16 is short;
  // data_first puts data before fmt; junk adds an odd-length chunk in front
  function automatic void build_wav(logic [15:0] code, logic [15:0] sub, int bits, int chans,
                                    logic [31:0] rate, int fmt_len, int data_len,
                                    bit data_first, bit junk, bit trailer);
    int bsz;
    logic [63:0] w;
    logic [7:0] body[$];
    put_tag("RIFF");
    put_le($urandom, 4);
    put_tag("WAVE");
    if (junk) begin
      put_tag("LIST");
      put_le(3, 4);
      put_le($urandom, 3);
      wav_buf.push_back(8'($urandom));   // pad byte
    end
    bsz = (bits >= 8) ? bits / 8 : 1;
    for (int i = 0; i < data_len; i++)
      body.push_back(data_fill.size() > 0 ? data_fill.pop_front() : 8'($urandom));
    // steer some double samples into the special exponent ranges
    if (bits == 64 && code != FMT_PCM)
      for (int i = 0; i + 8 <= data_len; i += 8) begin
        for (int k = 0; k < 8; k++) w[8*k +: 8] = body[i+k];
        case ($urandom_range(0, 7))
          0: w[62:52] = 11'h7FF;
          1: w[62:52] = 11'h000;
          2: w[62:52] = 11'(896 - $urandom_range(0, 26));
          3: w[62:52] = 11'(1150 + $urandom_range(0, 2));
          4: w[62:52] = 11'(1023 + $urandom_range(0, 10) - 5);
          5: w[51:0] = {23'h7FFFFF, 29'h10000000 | 29'($urandom_range(0, 1))};
          default: ;
        endcase
        for (int k = 0; k < 8; k++) body[i+k] = w[8*k +: 8];
      end
    for (int pass = 0; pass < 2; pass++) begin
      if ((pass == 0) == data_first) begin
        put_tag("data");
        put_le(data_len, 4);
        foreach (body[i]) wav_buf.push_back(body[i]);
        if (data_len % 2) wav_buf.push_back(8'($urandom));
      end else begin
        put_tag("fmt ");
        put_le(fmt_len, 4);
        for (int i = 0; i < fmt_len; i++) begin
          case (i)
            0, 1: wav_buf.push_back(code[8*(i%2) +: 8]);
            2, 3: wav_buf.push_back(8'(16'(chans) >> (8*(i%2))));
            4, 5, 6, 7: wav_buf.push_back(rate[8*(i-4) +: 8]);
            12: wav_buf.push_back(8'(bsz * chans));
            14, 15: wav_buf.push_back(8'(16'(bits) >> (8*(i%2))));
            24, 25: wav_buf.push_back(sub[8*(i-24) +: 8]);
            default: wav_buf.push_back(8'($urandom));
          endcase
        end
        if (fmt_len % 2) wav_buf.push_back(8'($urandom));
      end
    end
    if (trailer) begin
      put_tag($urandom_range(0, 1) ? "data" : "fmt ");
      put_le(2, 4);
      put_le($urandom, 2);
    end
  endfunction

  function automatic void random_file(bit hold);
    int pick, bits, chans, dlen, flen;
    logic [15:0] code, sub;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      // noise: random bytes, sometimes a real header in front
      if ($urandom_range(0, 1)) begin
        put_tag("RIFF");
        put_le($urandom, 4);
        put_tag("WAVE");
      end
      repeat ($urandom_range(1, 30)) wav_buf.push_back(8'($urandom));
      send_file(0, hold);
      return;
    end
    case ($urandom_range(0, 5))
      0: begin code = FMT_PCM; bits = 8; end
      1: begin code = FMT_PCM; bits = 16; end
      2: begin code = FMT_PCM; bits = 24; end
      3: begin code = FMT_PCM; bits = 32; end
      4: begin code = FMT_FLT; bits = 32; end
      default: begin code = FMT_FLT; bits = 64; end
    endcase
    sub = code;
    flen = ($urandom_range(0, 3) == 0) ? 16 + $urandom_range(1, 3) : 16;
    if ($urandom_range(0, 4) == 0) begin
      code = FMT_EXT;
      flen = 40;
    end
    chans = $urandom_range(1, 3);
    if (pick >= 85) begin
      // broken: one field or the layout goes wrong
      case ($urandom_range(0, 5))
        0: code = 16'($urandom);
        1: bits = $urandom_range(0, 70);
        2: chans = 0;
        3: flen = $urandom_range(0, 15);
        default: ;
      endcase
    end
    dlen = (bits / 8) * chans * $urandom_range(0, 4) + $urandom_range(0, 3);
    if (pick >= 85 && $urandom_range(0, 3) == 0) dlen = $urandom_range(0, 3);
    build_wav(code, sub, bits, chans, (pick >= 97) ? 0 : $urandom_range(1, 200000),
              flen, dlen, pick >= 85 && $urandom_range(0, 3) == 0,
              $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
    send_file((pick >= 85 && $urandom_range(0, 1)) ? $urandom_range(1, 12) : 0, hold);
  endfunction

  // ---------------- stimulus ----------------
  initial begin
    int fb;
    clear_parser();
    // extremes of each sample width
    data_fill = '{8'h00, 8'hFF, 8'h80, 8'h7F};
    build_wav(FMT_PCM, 0, 8, 1, 32'hFFFFFFFF, 16, 4, 0, 0, 0);
    send_file(0, 0);
    data_fill = '{8'h00, 8'h80, 8'hFF, 8'h7F, 8'h01, 8'h00, 8'hFF, 8'hFF};
    build_wav(FMT_PCM, 0, 16, 2, 48000, 16, 8, 0, 0, 0);
    send_file(0, 0);
    data_fill = '{8'h00, 8'h00, 8'h80, 8'hFF, 8'hFF, 8'h7F};
    build_wav(FMT_PCM, 0, 24, 1, 1, 18, 6, 0, 1, 0);
    send_file(0, 0);
    // int32 rounding: carry into the exponent
    data_fill = '{8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h80,
                  8'hC0, 8'h00, 8'h00, 8'h01, 8'h40, 8'h00, 8'h00, 8'h03};
    build_wav(FMT_PCM, 0, 32, 4, 44100, 16, 16, 0, 0, 1);
    send_file(0, 0);
    build_wav(FMT_FLT, 0, 32, 1, 8000, 16, 8, 0, 0, 0);
    send_file(0, 0);
    build_wav(FMT_EXT, FMT_FLT, 64, 2, 96000, 40, 48, 0, 0, 0);
    send_file(0, 0);
    build_wav(FMT_EXT, 16'h0055, 16, 1, 8000, 40, 4, 0, 0, 0);    // bad encoding
    send_file(0, 0);
    build_wav(FMT_PCM, 0, 12, 1, 8000, 16, 4, 0, 0, 0);           // bad format
    send_file(0, 0);
    build_wav(FMT_PCM, 0, 32, 2, 8000, 16, 7, 0, 0, 0);           // no whole frame
    send_file(0, 0);
    build_wav(FMT_PCM, 0, 16, 1, 8000, 16, 0, 0, 0, 0);           // empty data
    send_file(0, 0);
    build_wav(FMT_PCM, 0, 16, 1, 8000, 16, 4, 1, 0, 0);           // data before fmt
    send_file(0, 0);
    build_wav(FMT_PCM, 0, 16, 1, 8000, 12, 4, 0, 0, 0);           // short fmt
    send_file(0, 0);
    build_wav(FMT_PCM, 0, 16, 2, 8000, 16, 12, 0, 0, 0);          // truncated data
    send_file(3, 0);
    put_tag("RIFX");                                               // bad tag
    put_le(0, 4);
    put_le(0, 4);
    send_file(0, 0);
    put_le(32'h46464952, 4);                                       // short header
    send_file(0, 0);

    // random files; one pause until the decoder has drained
    fb = 0;
    while (pending_bytes.size() < 1300) begin
      random_file(fb == 10);
      fb++;
    end
  end

  // ---------------- driver ----------------
  int  gap_left = 0;
  int  burst_left = 0;
  bit  idle_mode = 1;

  always @(posedge clk) begin
    byte_item_t it;
    bit busy;
    if (rst) begin
      in_valid <= 0;
      file_byte <= 0;
      last_byte <= 0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        predict_byte(file_byte, last_byte);
        busy = 0;
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 0;
        end else if (pending_bytes.size() > 0 &&
                     !(pending_bytes[0].hold && expected_results.size() > 0)) begin
          it = pending_bytes.pop_front();
          file_byte <= it.fbyte;
          last_byte <= it.lastb;
          in_valid <= 1;
          // alternate stretches of random gaps with back-to-back runs
          if (burst_left == 0) begin
            idle_mode = ~idle_mode;
            burst_left = $urandom_range(20, 150);
          end
          burst_left--;
          gap_left = idle_mode ? $urandom_range(0, 8) : 0;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // ---------------- monitor ----------------
  int stall_left = 0;

  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          failed = 1;
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: kind %0d value %h", result_kind, sample_value);
        end else begin
          e = expected_results.pop_front();
          if (result_kind !== e.kind || sample_value !== e.val || channel_index !== e.chan ||
              status !== e.st || sample_rate !== e.rate || channel_count !== e.cnt ||
              last !== e.lst) begin
            failed = 1;
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: exp k%0d v%h ch%0d st%0d r%0d c%0d l%0d",
                       e.kind, e.val, e.chan, e.st, e.rate, e.cnt, e.lst);
              $display("          got k%0d v%h ch%0d st%0d r%0d c%0d l%0d",
                       result_kind, sample_value, channel_index, status,
                       sample_rate, channel_count, last);
            end
          end
        end
        stall_left = idle_mode ? $urandom_range(0, 8) : 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------- reset and end of run ----------------
  initial begin
    rst = 1;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    wait (pending_bytes.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (200) @(posedge clk);
    if (expected_results.size() > 0) failed = 1;
    if (!failed) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
